@@ hw/rtl/mcg_pkg.sv @@
// Shared widths, register indexes, constants and the status type of the metronome click generator.
`timescale 1ns / 1ps

package mcg_pkg;

   // Field widths.
   localparam int AUDIO_W     = 24;
   localparam int POS_W       = 48;
   localparam int IDX_W       = 48;
   localparam int SPB_W       = 32;
   localparam int GAIN_W      = 16;
   localparam int BPB_W       = 6;
   localparam int PHASE_W     = 24;
   localparam int ENV_W       = 17;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPB           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEATS_PER_BAR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_STEP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWNBEAT_STEP = 3'd5;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  GAIN_RESET          = 16'd32768;
   localparam logic [BPB_W-1:0]   BPB_RESET           = 6'd4;
   localparam logic [PHASE_W-1:0] BEAT_STEP_RESET     = 24'd349525;
   localparam logic [PHASE_W-1:0] DOWNBEAT_STEP_RESET = 24'd699051;

   // Audio limits and the unity envelope in Q16.
   localparam int AUDIO_MAX = 8388607;
   localparam int AUDIO_MIN = -8388608;
   localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

   // Sine table build constants, Q2.30.
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Status of a serial divider as seen by its user.
   typedef struct packed {
      logic busy;
      logic q_bit;
   } div_status_type;

endpackage

@@ hw/rtl/mcg_req_if.sv @@
// Input channel of the metronome click generator: one stereo sample with its transport position.
`timescale 1ns / 1ps

interface mcg_req_if;
   import mcg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [AUDIO_W-1:0] left_in;
   logic signed [AUDIO_W-1:0] right_in;
   logic signed [POS_W-1:0]   position;
   logic                      playing;

   modport source (output valid, left_in, right_in, position, playing, input ready);
   modport sink (input valid, left_in, right_in, position, playing, output ready);
endinterface

@@ hw/rtl/mcg_rsp_if.sv @@
// Result channel of the metronome click generator: one stereo sample with the click mixed in.
`timescale 1ns / 1ps

interface mcg_rsp_if;
   import mcg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [AUDIO_W-1:0] left_out;
   logic signed [AUDIO_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ hw/rtl/metronome_click_generator_top.sv @@
// Metronome click generator: mixes a decaying sine click into a stereo stream on every beat.
`timescale 1ns / 1ps

// Each accepted beat carries one stereo Q1.23 sample, its transport position and a playing
// flag, and yields exactly one result beat. With mixing enabled, playing and a non-zero
// tempo, the beat index floor(position*256 / samples_per_beat) is found by a serial
// divider that delivers one quotient bit per cycle; the index modulo beats_per_bar is
// built from the same quotient bits as they appear, so the downbeat decision costs no
// extra time. A rising index starts a click of CLICK_LENGTH samples. The click sample
// is read from a sine ROM, scaled by gain and by the squared envelope, and added to both
// channels with saturation. A sample that goes through the index division reaches the
// output state once all 55 quotient bits are out; when a click is mixed in, it first passes
// the address, ROM, multiply, rounding and second multiply states. A sample with a negative
// position waits only for the 17 quotient bits of the envelope division. A sample that
// passes through untouched (disabled, stopped, or zero tempo) goes straight to the output
// state. One sample is in work at a time; the block is ready for the next as soon as the
// current one has been placed in the output register, even if that result has not yet
// been taken. The user must write configuration through csr_write_enable, csr_index and
// csr_write_data only while no sample is in work; the block does not enforce this. Writes
// to indexes beyond the register list are ignored.

module metronome_click_generator_top #(
   parameter int CLICK_LENGTH     = 1024,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   mcg_req_if.sink                             req_bus,
   mcg_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [mcg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcg_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import mcg_pkg::*;

   // Derived sizes.
   localparam int CLK_W      = $clog2(CLICK_LENGTH + 1);
   localparam int ROM_AW     = $clog2(SINE_TABLE_DEPTH);
   localparam int SCALED_W   = PHASE_W + ROM_AW;
   localparam int IDX_QW     = 55;                  // quotient bits of position*256 / spb
   localparam int IDX_DVD_W  = IDX_QW + 1;
   localparam int LEN2_W     = 2 * CLK_W;
   localparam int ENV_DVD_W  = LEN2_W + 17;
   localparam int CNT_W      = $clog2(IDX_QW);
   localparam int P1_W       = 41;                  // sine times gain
   localparam int A_W        = 26;                  // gain-scaled sine
   localparam int P2_W       = 44;                  // scaled sine times envelope
   localparam int SUM_W      = 27;

   localparam longint unsigned LEN2      = longint'(CLICK_LENGTH) * longint'(CLICK_LENGTH);
   localparam longint unsigned D64       = longint'(SINE_TABLE_DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_ADDR = 3'd2;
   localparam logic [2:0] S_ROM  = 3'd3;
   localparam logic [2:0] S_MUL1 = 3'd4;
   localparam logic [2:0] S_RND  = 3'd5;
   localparam logic [2:0] S_MUL2 = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   // One sine table entry, built at elaboration with an odd Taylor series in Q2.30
   // over a quarter wave, then mirrored into the other quadrants.
   function automatic logic signed [AUDIO_W-1:0] sine_entry(input longint unsigned k);
      longint unsigned m;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned q;
      logic signed [AUDIO_W-1:0] v;
      m    = 64'd4 * k;
      quad = (m / D64) & 64'd3;
      r    = m % D64;
      if (quad[0]) begin
         r = D64 - r;
      end
      x  = (r * HALF_PI_Q30 + D64 / 64'd2) / D64;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      q  = (s + 64'd64) >> 7;
      if (q > 64'(AUDIO_MAX)) begin
         q = 64'(AUDIO_MAX);
      end
      v = AUDIO_W'(q);
      return (quad >= 64'd2) ? -v : v;
   endfunction

   function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(AUDIO_MAX)) begin
         return AUDIO_W'(AUDIO_MAX);
      end else if (v < SUM_W'(AUDIO_MIN)) begin
         return AUDIO_W'(AUDIO_MIN);
      end
      return v[AUDIO_W-1:0];
   endfunction

   // Sine ROM, one entry per table position, read through a register.
   logic signed [AUDIO_W-1:0] sine_rom [SINE_TABLE_DEPTH];

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam logic signed [AUDIO_W-1:0] ENTRY = sine_entry(64'(g));
      assign sine_rom[g] = ENTRY;
   end

   // Configuration registers.
   logic                  enable_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [SPB_W-1:0]      spb_ff;
   logic [BPB_W-1:0]      bpb_ff;
   logic [PHASE_W-1:0]    beat_step_ff;
   logic [PHASE_W-1:0]    down_step_ff;

   // Beat tracker and click state.
   logic [IDX_W-1:0]      prev_idx_ff;
   logic                  prev_valid_ff;
   logic [CLK_W-1:0]      click_rem_ff;
   logic [PHASE_W-1:0]    tone_phase_ff;
   logic                  is_downbeat_ff;

   // Sequencer and work registers.
   logic [2:0]            state_ff;
   logic                  idx_run_ff;
   logic                  mix_ff;
   logic [CNT_W-1:0]      idx_cnt_ff;
   logic [BPB_W-1:0]      mod_ff;
   logic [BPB_W-1:0]      ones_ff;
   logic signed [AUDIO_W-1:0] left_ff;
   logic signed [AUDIO_W-1:0] right_ff;
   logic [ENV_W-1:0]      env_ff;
   logic [ROM_AW-1:0]     k_ff;
   logic signed [AUDIO_W-1:0] sine_ff;
   logic signed [P1_W-1:0] prod1_ff;
   logic signed [A_W-1:0]  a_ff;
   logic signed [P2_W-1:0] prod2_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic signed [AUDIO_W-1:0] left_out_ff;
   logic signed [AUDIO_W-1:0] right_out_ff;

   // Handshakes.
   logic req_fire;
   logic out_free;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_out_ff;
   assign rsp_bus.right_out = right_out_ff;

   // Dividers: the beat index and the envelope of the click in progress.
   logic                   track;
   logic                   idx_start;
   logic [IDX_DVD_W-1:0]   idx_dividend;
   logic [IDX_QW-1:0]      idx_quot;
   div_status_type         idx_stat;
   logic [LEN2_W-1:0]      rem_sq;
   logic [ENV_DVD_W-1:0]   env_dividend;
   logic [ENV_W-1:0]       env_quot;
   div_status_type         env_stat;

   assign track        = req_fire && enable_ff && req_bus.playing && (spb_ff != '0);
   assign idx_start    = track && !req_bus.position[POS_W-1];
   assign idx_dividend = {1'b0, req_bus.position[POS_W-2:0], 8'b0};
   assign rem_sq       = LEN2_W'(click_rem_ff) * LEN2_W'(click_rem_ff);
   assign env_dividend = ENV_DVD_W'({rem_sq, 16'b0}) + ENV_DVD_W'(LEN2 / 64'd2);

   mcg_serial_div #(
      .DIVIDEND_W (IDX_DVD_W),
      .DIVISOR_W  (SPB_W),
      .QUOT_W     (IDX_QW)
   ) u_idx_div (
      .clock    (clock),
      .reset    (reset),
      .start    (idx_start),
      .dividend (idx_dividend),
      .divisor  (spb_ff),
      .quotient (idx_quot),
      .status   (idx_stat)
   );

   mcg_serial_div #(
      .DIVIDEND_W (ENV_DVD_W),
      .DIVISOR_W  (LEN2_W),
      .QUOT_W     (ENV_W)
   ) u_env_div (
      .clock    (clock),
      .reset    (reset),
      .start    (track),
      .dividend (env_dividend),
      .divisor  (LEN2_W'(LEN2)),
      .quotient (env_quot),
      .status   (env_stat)
   );

   // Bar position: the quotient bits are folded into a remainder modulo beats_per_bar as
   // they leave the divider. A second remainder follows an all-ones index, which is the
   // value used when the quotient overflows 48 bits.
   logic [BPB_W-1:0] bpb_eff;
   logic [BPB_W:0]   mod_trial;
   logic [BPB_W:0]   ones_trial;
   logic [BPB_W-1:0] mod_in;
   logic [BPB_W-1:0] ones_in;

   assign bpb_eff    = (bpb_ff == '0) ? BPB_W'(1) : bpb_ff;
   assign mod_trial  = {mod_ff, idx_stat.q_bit};
   assign ones_trial = {ones_ff, 1'b1};
   assign mod_in     = (mod_trial >= {1'b0, bpb_eff})
                     ? BPB_W'(mod_trial - {1'b0, bpb_eff}) : mod_trial[BPB_W-1:0];
   assign ones_in    = (ones_trial >= {1'b0, bpb_eff})
                     ? BPB_W'(ones_trial - {1'b0, bpb_eff}) : ones_trial[BPB_W-1:0];

   // Beat decision once both divisions are done.
   logic             div_done;
   logic             idx_over;
   logic [IDX_W-1:0] idx_sat;
   logic             bar_hit;
   logic             restart;
   logic [CLK_W-1:0] rem_after;

   assign div_done  = !idx_stat.busy && !env_stat.busy;
   assign idx_over  = |idx_quot[IDX_QW-1:IDX_W];
   assign idx_sat   = idx_over ? '1 : idx_quot[IDX_W-1:0];
   assign bar_hit   = idx_over ? (ones_ff == '0) : (mod_ff == '0);
   assign restart   = idx_run_ff && prev_valid_ff && (idx_sat > prev_idx_ff);
   assign rem_after = restart ? CLK_W'(CLICK_LENGTH) : click_rem_ff;

   // Click datapath: table address, gain, rounding and envelope.
   logic [SCALED_W-1:0]    phase_scaled;
   logic signed [P1_W-1:0] prod1_in;
   logic                   p1_neg;
   logic [P1_W-1:0]        p1_mag;
   logic [P1_W-1:0]        p1_rnd;
   logic signed [A_W-1:0]  a_in;
   logic signed [P2_W-1:0] prod2_in;
   logic                   p2_neg;
   logic [P2_W-1:0]        p2_mag;
   logic [P2_W-1:0]        p2_rnd;
   logic signed [A_W-1:0]  click;
   logic signed [SUM_W-1:0] sum_left;
   logic signed [SUM_W-1:0] sum_right;

   assign phase_scaled = SCALED_W'(tone_phase_ff) * SCALED_W'(SINE_TABLE_DEPTH);
   assign prod1_in     = P1_W'(sine_ff) * P1_W'($signed({1'b0, gain_ff}));

   // Both roundings take halves away from zero, so they work on the magnitude.
   assign p1_neg = prod1_ff[P1_W-1];
   assign p1_mag = p1_neg ? P1_W'(-prod1_ff) : P1_W'(prod1_ff);
   assign p1_rnd = (p1_mag + P1_W'(1 << 14)) >> 15;
   assign a_in   = p1_neg ? -A_W'(p1_rnd) : A_W'(p1_rnd);

   assign prod2_in = P2_W'(a_ff) * P2_W'($signed({1'b0, env_ff}));
   assign p2_neg   = prod2_ff[P2_W-1];
   assign p2_mag   = p2_neg ? P2_W'(-prod2_ff) : P2_W'(prod2_ff);
   assign p2_rnd   = (p2_mag + P2_W'(1 << 15)) >> 16;
   assign click    = mix_ff ? (p2_neg ? -A_W'(p2_rnd) : A_W'(p2_rnd)) : '0;

   assign sum_left  = SUM_W'(left_ff) + SUM_W'(click);
   assign sum_right = SUM_W'(right_ff) + SUM_W'(click);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         gain_ff      <= GAIN_RESET;
         spb_ff       <= '0;
         bpb_ff       <= BPB_RESET;
         beat_step_ff <= BEAT_STEP_RESET;
         down_step_ff <= DOWNBEAT_STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:        enable_ff    <= csr_write_data[0];
            CSR_GAIN:          gain_ff      <= csr_write_data[GAIN_W-1:0];
            CSR_SPB:           spb_ff       <= csr_write_data[SPB_W-1:0];
            CSR_BEATS_PER_BAR: bpb_ff       <= csr_write_data[BPB_W-1:0];
            CSR_BEAT_STEP:     beat_step_ff <= csr_write_data[PHASE_W-1:0];
            CSR_DOWNBEAT_STEP: down_step_ff <= csr_write_data[PHASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Bar remainders follow the index divider bit by bit.
   always_ff @(posedge clock) begin
      if (idx_start) begin
         mod_ff     <= '0;
         ones_ff    <= '0;
         idx_cnt_ff <= '0;
      end else if (idx_stat.busy) begin
         mod_ff     <= mod_in;
         idx_cnt_ff <= idx_cnt_ff + CNT_W'(1);
         if (idx_cnt_ff >= CNT_W'(IDX_QW - IDX_W)) begin
            ones_ff <= ones_in;
         end
      end
   end

   // Sequencer, tracker and click state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_run_ff     <= 1'b0;
         mix_ff         <= 1'b0;
         prev_idx_ff    <= '0;
         prev_valid_ff  <= 1'b0;
         click_rem_ff   <= '0;
         tone_phase_ff  <= '0;
         is_downbeat_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  mix_ff <= 1'b0;
                  priority if (!enable_ff) begin
                     state_ff <= S_OUT;
                  end else if (!req_bus.playing) begin
                     prev_valid_ff <= 1'b0;
                     prev_idx_ff   <= '0;
                     click_rem_ff  <= '0;
                     state_ff      <= S_OUT;
                  end else if (spb_ff == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     idx_run_ff <= !req_bus.position[POS_W-1];
                     if (req_bus.position[POS_W-1]) begin
                        prev_idx_ff   <= '0;
                        prev_valid_ff <= 1'b0;
                     end
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (idx_run_ff) begin
                     prev_idx_ff   <= idx_sat;
                     prev_valid_ff <= 1'b1;
                  end
                  if (restart) begin
                     click_rem_ff   <= CLK_W'(CLICK_LENGTH);
                     tone_phase_ff  <= '0;
                     is_downbeat_ff <= bar_hit;
                  end
                  mix_ff   <= (rem_after != '0);
                  state_ff <= (rem_after != '0) ? S_ADDR : S_OUT;
               end
            end
            S_ADDR: state_ff <= S_ROM;
            S_ROM:  state_ff <= S_MUL1;
            S_MUL1: state_ff <= S_RND;
            S_RND:  state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  if (mix_ff) begin
                     tone_phase_ff <= tone_phase_ff
                                    + (is_downbeat_ff ? down_step_ff : beat_step_ff);
                     click_rem_ff  <= click_rem_ff - CLK_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff  <= req_bus.left_in;
         right_ff <= req_bus.right_in;
      end
      if (state_ff == S_DIV && div_done) begin
         env_ff <= restart ? ENV_ONE : env_quot;
      end
      if (state_ff == S_ADDR) begin
         k_ff <= phase_scaled[SCALED_W-1:PHASE_W];
      end
      if (state_ff == S_ROM) begin
         sine_ff <= sine_rom[k_ff];
      end
      if (state_ff == S_MUL1) begin
         prod1_ff <= prod1_in;
      end
      if (state_ff == S_RND) begin
         a_ff <= a_in;
      end
      if (state_ff == S_MUL2) begin
         prod2_ff <= prod2_in;
      end
      if (state_ff == S_OUT && out_free) begin
         left_out_ff  <= sat24(sum_left);
         right_out_ff <= sat24(sum_right);
      end
   end

endmodule

@@ hw/rtl/mcg_serial_div.sv @@
// Restoring divider that produces one quotient bit per cycle, most significant bit first.
`timescale 1ns / 1ps

module mcg_serial_div #(
   parameter int DIVIDEND_W = 56,
   parameter int DIVISOR_W  = 32,
   parameter int QUOT_W     = 55
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   input  logic [DIVISOR_W-1:0]          divisor,
   output logic [QUOT_W-1:0]             quotient,
   output mcg_pkg::div_status_type       status
);
   import mcg_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   // The bits above the quotient field form the first partial remainder; the caller
   // guarantees they are below the divisor.
   logic [DIVISOR_W-1:0] rem_ff;
   logic [QUOT_W-1:0]    quo_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;

   logic [DIVISOR_W:0]   trial;
   logic                 take;
   logic [DIVISOR_W-1:0] rem_in;

   assign trial  = {rem_ff, quo_ff[QUOT_W-1]};
   assign take   = trial >= {1'b0, divisor_ff};
   assign rem_in = take ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(QUOT_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
         quo_ff     <= dividend[QUOT_W-1:0];
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUOT_W-2:0], take};
      end
   end

   assign quotient     = quo_ff;
   assign status.busy  = busy_ff;
   assign status.q_bit = take;

endmodule
